// ===== hw/rtl/lkt_pkg.sv =====
// lkt_pkg: types and constants shared by the lru key tracker modules
// no dependencies; used by lkt_ctrl, lkt_dp and lru_key_tracker
`default_nettype none

package lkt_pkg;

  localparam int unsigned KeyWidth = 8;
  localparam int unsigned OccWidth = 4;
  localparam int unsigned CapWidth = 4;
  localparam logic [CapWidth-1:0] CapReset = 4'd8;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lkt_ctrl.sv =====
// lkt_ctrl: handshake controller for the lru key tracker
// depends on lkt_pkg; drives lkt_dp through lkt_pkg::cmd_t
`default_nettype none

module lkt_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output lkt_pkg::cmd_t     cmd
);

  lkt_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lkt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      lkt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = lkt_pkg::S_UPD;
        end
      end
      lkt_pkg::S_UPD: begin
        // result slot free or being emptied this cycle
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = lkt_pkg::S_IDLE;
        end
      end
      default: state_next = lkt_pkg::S_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_capture_to_upd: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == lkt_pkg::S_UPD)
    else $error("capture not followed by update");

  a_commit_in_upd: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> state == lkt_pkg::S_UPD)
    else $error("commit outside update state");

  a_commit_gives_word: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed word not presented");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == lkt_pkg::S_UPD && out_valid && !out_ready) |=> state == lkt_pkg::S_UPD)
    else $error("update overran an unread word");

  a_no_capture_and_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit together");

endmodule

`default_nettype wire

// ===== hw/rtl/lkt_dp.sv =====
// lkt_dp: key store, parallel lookup, shift update and result register
// depends on lkt_pkg; sequenced by lkt_ctrl through lkt_pkg::cmd_t
`default_nettype none

module lkt_dp #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lkt_pkg::cmd_t                     cmd,
  input  wire logic                              cfg_we,
  input  wire logic [lkt_pkg::CapWidth-1:0]      cfg_data,
  input  wire logic [lkt_pkg::KeyWidth-1:0]      key,
  output logic                                   hit,
  output logic                                   evicted,
  output logic [lkt_pkg::KeyWidth-1:0]           evicted_key,
  output logic [lkt_pkg::OccWidth-1:0]           occupancy
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW   = (CntW > lkt_pkg::CapWidth) ? CntW : lkt_pkg::CapWidth;
  localparam int unsigned OW   = (EW > lkt_pkg::OccWidth) ? EW : lkt_pkg::OccWidth;
  localparam logic [EW-1:0] MaxE = EW'(MAX_ENTRIES);

  logic [lkt_pkg::KeyWidth-1:0] store [MAX_ENTRIES];
  logic [CntW-1:0]              count;
  logic [lkt_pkg::CapWidth-1:0] capacity;
  logic [lkt_pkg::KeyWidth-1:0] key_q;
  logic [MAX_ENTRIES-1:0]       match_q;

  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] shift;
  logic [EW-1:0]          cap_e;
  logic [EW-1:0]          cap_eff;
  logic [EW-1:0]          cnt_e;
  logic                   is_hit;
  logic                   room;
  logic [CntW-1:0]        count_next;
  logic [OW-1:0]          occ_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkt_pkg::CapReset;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // lookup against held entries at accept
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = (CntW'(i) < count) && (store[i] == key);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_q   <= key;
      match_q <= match;
    end
  end

  always_comb begin
    cap_e = EW'(capacity);
    if (cap_e == '0) begin
      cap_eff = EW'(1);
    end else if (cap_e > MaxE) begin
      cap_eff = MaxE;
    end else begin
      cap_eff = cap_e;
    end
    cnt_e  = EW'(count);
    is_hit = |match_q;
    room   = cnt_e < cap_eff;
    // matches are unique, so everything from the match upward moves
    shift  = is_hit ? ~(match_q - MAX_ENTRIES'(1)) : '1;
    count_next = (!is_hit && room) ? count + CntW'(1) : count;
    occ_w  = OW'(count_next);
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (!is_hit && room) begin
          if (CntW'(i) == count) begin
            store[i] <= key_q;
          end
        end else if (shift[i]) begin
          if (CntW'(i + 1) < count) begin
            store[i] <= store[(i + 1) % MAX_ENTRIES];
          end else if (CntW'(i + 1) == count) begin
            store[i] <= key_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= is_hit;
      evicted     <= !is_hit && !room;
      evicted_key <= (!is_hit && !room) ? store[0] : '0;
      occupancy   <= occ_w[lkt_pkg::OccWidth-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lru_key_tracker.sv =====
// lru_key_tracker: top level of the least-recently-used byte key tracker
// depends on lkt_pkg, lkt_ctrl and lkt_dp
//
//   channel  signals                                       direction
//   in       in_valid, in_ready, key                       word in
//   out      out_valid, out_ready, hit, evicted,           word out
//            evicted_key, occupancy
//   cfg      cfg_we, cfg_data (capacity)                   write only
//
// each word: accept with parallel key compare, then shift update
// the update cycle waits while the previous result word is still unread
// a new word is accepted while a finished result waits in the output register
// reset is synchronous; the store needs no clearing, the count starts at zero
`default_nettype none

module lru_key_tracker #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lkt_pkg::KeyWidth-1:0]  key,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               hit,
  output logic                               evicted,
  output logic [lkt_pkg::KeyWidth-1:0]       evicted_key,
  output logic [lkt_pkg::OccWidth-1:0]       occupancy,
  input  wire logic                          cfg_we,
  input  wire logic [lkt_pkg::CapWidth-1:0]  cfg_data
);

  lkt_pkg::cmd_t cmd;

  lkt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .key         (key),
    .hit         (hit),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .occupancy   (occupancy)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for lru_key_tracker, the lru byte key tracker
// keeps its own recency list to predict every result word and compares field by field
// depends on lkt_pkg and lru_key_tracker
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned KeyWidth = lkt_pkg::KeyWidth;
  localparam int unsigned OccWidth = lkt_pkg::OccWidth;
  localparam int unsigned CapWidth = lkt_pkg::CapWidth;
  localparam logic [CapWidth-1:0] CapReset = lkt_pkg::CapReset;

  localparam int unsigned MaxEntries = 8;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic                hit;
    logic                evicted;
    logic [KeyWidth-1:0] evicted_key;
    logic [OccWidth-1:0] occupancy;
  } access_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [KeyWidth-1:0] key;
  logic                out_valid;
  logic                out_ready;
  logic                hit;
  logic                evicted;
  logic [KeyWidth-1:0] evicted_key;
  logic [OccWidth-1:0] occupancy;
  logic                cfg_we;
  logic [CapWidth-1:0] cfg_data;

  // predictor state
  logic [KeyWidth-1:0] recency_list [MaxEntries];
  int unsigned         keys_held;
  logic [CapWidth-1:0] capacity_reg;

  access_result_t      expected_results [$];
  logic [KeyWidth-1:0] key_pool [12];
  int unsigned         sender_idle_pct;
  int unsigned         stall_pct;
  int unsigned         hold_req;
  int unsigned         hold_left;
  int unsigned         error_count;
  int unsigned         cycle_count;

  lru_key_tracker #(
    .MAX_ENTRIES(MaxEntries)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key        (key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .evicted    (evicted),
    .evicted_key(evicted_key),
    .occupancy  (occupancy),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic access_result_t predict_access(input logic [KeyWidth-1:0] k);
    access_result_t r;
    int unsigned    limit;
    int unsigned    pos;
    bit             found;
    r = '0;
    found = 1'b0;
    pos = 0;
    limit = capacity_reg;
    if (limit < 1) limit = 1;
    if (limit > MaxEntries) limit = MaxEntries;
    for (int unsigned i = 0; i < keys_held; i++) begin
      if (!found && recency_list[i] == k) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      for (int unsigned i = pos; i + 1 < keys_held; i++) recency_list[i] = recency_list[i + 1];
      recency_list[keys_held - 1] = k;
    end else if (keys_held < limit) begin
      recency_list[keys_held] = k;
      keys_held++;
    end else begin
      r.evicted = 1'b1;
      r.evicted_key = recency_list[0];
      for (int unsigned i = 0; i + 1 < keys_held; i++) recency_list[i] = recency_list[i + 1];
      recency_list[keys_held - 1] = k;
    end
    r.occupancy = keys_held[OccWidth-1:0];
    return r;
  endfunction

  // offer one word, with random idle cycles first, and predict it once taken
  task automatic send_key(input logic [KeyWidth-1:0] k);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key <= k;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_access(k));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CapWidth-1:0] c);
    cfg_we <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_reg = c;
  endtask

  task automatic test_sole_entry();
    sender_idle_pct = 0;
    stall_pct = 0;
    set_capacity(4'd0);
    send_key(8'h00);
    send_key(8'h00);
    send_key(8'hFF);
    send_key(8'hFF);
    wait_drained();
  endtask

  task automatic test_fill_and_reorder();
    set_capacity(4'd2);
    send_key(8'h5A);
    send_key(8'hFF);
    send_key(8'hFF);
    send_key(8'hA5);
    wait_drained();
    set_capacity(4'd15);
    send_key(8'h01);
    send_key(8'h02);
    send_key(8'h80);
    send_key(8'h7F);
    send_key(8'h3C);
    send_key(8'hC3);
    send_key(8'hFF);
    send_key(8'h80);
    send_key(8'h80);
    send_key(8'h42);
    wait_drained();
  endtask

  task automatic test_capacity_shrink();
    set_capacity(4'd3);
    send_key(8'h99);
    send_key(8'h7F);
    send_key(8'h00);
    wait_drained();
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall,
                                   input logic [CapWidth-1:0] cap, input int unsigned n_words);
    int unsigned pick;
    set_capacity(cap);
    sender_idle_pct = idle_pct;
    stall_pct = stall;
    foreach (key_pool[i]) key_pool[i] = KeyWidth'($urandom_range(255));
    for (int unsigned i = 0; i < n_words; i++) begin
      pick = $urandom_range(99);
      if (pick < 45 && keys_held != 0)
        send_key(recency_list[$urandom_range(keys_held - 1)]);
      else if (pick < 80)
        send_key(key_pool[$urandom_range(11)]);
      else
        send_key(KeyWidth'($urandom_range(255)));
    end
    wait_drained();
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_backpressure();
    set_capacity(4'd6);
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_req = 300;
    for (int unsigned i = 0; i < 20; i++) send_key(KeyWidth'($urandom_range(255)));
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    error_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    access_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: extra word, expected none, actual hit %0b evicted %0b key %0h occ %0d",
                 $time, hit, evicted, evicted_key, occupancy);
      end else begin
        exp_r = expected_results.pop_front();
        if (hit !== exp_r.hit) report_field("hit", exp_r.hit, hit);
        if (evicted !== exp_r.evicted) report_field("evicted", exp_r.evicted, evicted);
        if (evicted_key !== exp_r.evicted_key)
          report_field("evicted_key", exp_r.evicted_key, evicted_key);
        if (occupancy !== exp_r.occupancy) report_field("occupancy", exp_r.occupancy, occupancy);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    key = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    out_ready = 1'b0;
    hold_req = 0;
    hold_left = 0;
    error_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    keys_held = 0;
    capacity_reg = CapReset;
    foreach (recency_list[i]) recency_list[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sole_entry();
    test_fill_and_reorder();
    test_capacity_shrink();
    test_random_phase(0, 0, 4'd8, 320);
    test_random_phase(53, 0, 4'd1, 320);
    test_backpressure();
    test_random_phase(0, 53, 4'd15, 320);
    test_random_phase(14, 14, 4'd4, 320);
    test_random_phase(0, 0, 4'd0, 40);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lkt_pkg.sv
hw/rtl/lkt_ctrl.sv
hw/rtl/lkt_dp.sv
hw/rtl/lru_key_tracker.sv
tb/tb_top.sv
